// ===== rtl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// Context slot allocator package
// Shared sizes, types and command and status codes for the slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W  = 32;
    localparam int CNT_W = 7;

    typedef logic [IDX_W-1:0] slot_idx_t;
    typedef logic [ID_W-1:0]  ctx_id_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [1:0]       cmd_t;
    typedef logic [1:0]       status_t;

    localparam cmd_t CMD_CREATE = 2'd0;
    localparam cmd_t CMD_DELETE = 2'd1;
    localparam cmd_t CMD_LIST   = 2'd2;
    localparam cmd_t CMD_QUERY  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FAIL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);
    localparam ctx_id_t   FIRST_ID  = ctx_id_t'(1);

endpackage

// ===== rtl/csa_id_ram.sv =====
// ----------------------------------------------------------------------------
// Context id store
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module csa_id_ram (
    input  logic             clk,
    input  logic             wr_en,
    input  csa_pkg::slot_idx_t wr_addr,
    input  csa_pkg::ctx_id_t   wr_data,
    input  csa_pkg::slot_idx_t rd_addr,
    output csa_pkg::ctx_id_t   rd_data
);
    import csa_pkg::*;

    ctx_id_t mem [SLOTS];
    ctx_id_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/context_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Context slot allocator
// Results: create, delete and query give a single result once the slot scan
//   ends; a list gives its ids from the scan, at most one id per cycle;
//   an empty list answers next cycle.
// Commands: one command at a time; a new transfer is taken only once the
//   slot scan is done, and the scan reads one id entry per cycle.
// Reset: all slots free, the id counter at one, no clearing pass; no stalls.
// ----------------------------------------------------------------------------
module context_slot_allocator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  csa_pkg::cmd_t      command,
    input  csa_pkg::ctx_id_t   context_id,
    input  csa_pkg::count_t    list_limit,
    output logic               busy,
    output logic               result_valid,
    output csa_pkg::status_t   status,
    output csa_pkg::ctx_id_t   context_id_res,
    output logic               last
);
    import csa_pkg::*;

    // Controller states.
    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_SCAN = 1'b1;

    logic state_reg, state_next;

    // Latched command.
    cmd_t    cmd_reg;
    ctx_id_t id_reg;
    count_t  maxc_reg;

    // Scan issue stage: the slot whose id is being read from memory.
    slot_idx_t idx_reg, idx_next;
    logic      issue_reg, issue_next;

    // Evaluate stage: the slot whose id is now on the memory output.
    slot_idx_t rd_idx_reg;
    logic      rd_vld_reg, rd_vld_next;
    logic      rd_used_reg;
    ctx_id_t   rd_data;

    // Live slot flags, cleared by reset. The id memory itself needs no
    // reset because an id is only looked at while its flag is set.
    logic [SLOTS-1:0] slot_used_reg;
    ctx_id_t          next_id_reg;
    count_t           cnt_reg;

    // Result register.
    logic    res_valid_reg;
    status_t res_status_reg;
    ctx_id_t res_id_reg;
    logic    res_last_reg;

    // Evaluate stage decisions.
    logic    fire;
    status_t fire_status;
    ctx_id_t fire_id;
    logic    fire_last;
    logic    finish;
    logic    wr_en;
    logic    clr_en;
    logic    id_match;
    logic    live_after;
    logic    accept;
    logic    empty_list;
    ctx_id_t id_inc;

    assign accept = start && (state_reg == STATE_IDLE);

    // A list with nothing to return answers at once without a scan.
    assign empty_list = (command == CMD_LIST)
                        && ((list_limit == '0) || (slot_used_reg == '0));

    assign id_match = rd_used_reg && (rd_data == id_reg);

    // The counter skips zero when it wraps.
    assign id_inc = (next_id_reg + FIRST_ID == '0) ? FIRST_ID : next_id_reg + FIRST_ID;

    // Whether any slot above the one being evaluated is live. A list uses
    // this to mark its final id without looking further ahead.
    always_comb
    begin
        live_after = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (slot_used_reg[k] && (slot_idx_t'(k) > rd_idx_reg))
            begin
                live_after = 1'b1;
            end
        end
    end

    csa_id_ram u_id_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (next_id_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Evaluate one slot per cycle. A create, delete or query ends on the
    // first hit, or with a failure once the top slot has been seen.
    always_comb
    begin
        fire        = 1'b0;
        fire_status = ST_OK;
        fire_id     = '0;
        fire_last   = 1'b1;
        finish      = 1'b0;
        wr_en       = 1'b0;
        clr_en      = 1'b0;
        if (rd_vld_reg)
        begin
            case (cmd_reg)
                CMD_CREATE:
                begin
                    if (!rd_used_reg)
                    begin
                        wr_en   = 1'b1;
                        fire    = 1'b1;
                        fire_id = next_id_reg;
                        finish  = 1'b1;
                    end
                    else if (rd_idx_reg == LAST_SLOT)
                    begin
                        fire        = 1'b1;
                        fire_status = ST_FAIL;
                        finish      = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (id_match)
                    begin
                        clr_en = 1'b1;
                        fire   = 1'b1;
                        finish = 1'b1;
                    end
                    else if (rd_idx_reg == LAST_SLOT)
                    begin
                        fire        = 1'b1;
                        fire_status = ST_FAIL;
                        finish      = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    if (id_match)
                    begin
                        fire    = 1'b1;
                        fire_id = id_reg;
                        finish  = 1'b1;
                    end
                    else if (rd_idx_reg == LAST_SLOT)
                    begin
                        fire        = 1'b1;
                        fire_status = ST_FAIL;
                        finish      = 1'b1;
                    end
                end
                CMD_LIST:
                begin
                    if (rd_used_reg)
                    begin
                        fire      = 1'b1;
                        fire_id   = rd_data;
                        fire_last = (cnt_reg + count_t'(1) == maxc_reg) || !live_after;
                        finish    = fire_last;
                    end
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase
        end
    end

    // Next-state logic for the scan. Finishing squashes the read that is
    // already in flight.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        issue_next  = issue_reg;
        rd_vld_next = 1'b0;
        case (state_reg)
            STATE_IDLE:
            begin
                if (accept && !empty_list)
                begin
                    state_next = STATE_SCAN;
                    idx_next   = '0;
                    issue_next = 1'b1;
                end
            end
            STATE_SCAN:
            begin
                rd_vld_next = issue_reg;
                if (issue_reg)
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + slot_idx_t'(1);
                    end
                end
                if (finish)
                begin
                    state_next  = STATE_IDLE;
                    issue_next  = 1'b0;
                    rd_vld_next = 1'b0;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            slot_used_reg <= '0;
            next_id_reg   <= FIRST_ID;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            res_valid_reg <= fire || (accept && empty_list);
            if (wr_en)
            begin
                slot_used_reg[rd_idx_reg] <= 1'b1;
                next_id_reg               <= id_inc;
            end
            if (clr_en)
            begin
                slot_used_reg[rd_idx_reg] <= 1'b0;
            end
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (fire)
            begin
                cnt_reg <= cnt_reg + count_t'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            id_reg   <= context_id;
            maxc_reg <= list_limit;
        end
        rd_idx_reg  <= idx_reg;
        rd_used_reg <= slot_used_reg[idx_reg];
        if (accept && empty_list)
        begin
            res_status_reg <= ST_EMPTY;
            res_id_reg     <= '0;
            res_last_reg   <= 1'b1;
        end
        else if (fire)
        begin
            res_status_reg <= fire_status;
            res_id_reg     <= fire_id;
            res_last_reg   <= fire_last;
        end
    end

    assign busy           = (state_reg != STATE_IDLE);
    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign context_id_res = res_id_reg;
    assign last           = res_last_reg;

`ifndef NO_ASSERTIONS
    // A create only ever claims a slot that is free.
    a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !slot_used_reg[rd_idx_reg])
        else $error("create wrote a live slot");

    // Every accepted command is either scanning or answered next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid))
        else $error("accepted command was dropped");

    // The evaluate stage only holds data during a scan.
    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == STATE_SCAN))
        else $error("slot evaluated outside a scan");

    // The id counter never holds zero.
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("id counter reached zero");

    // A list never returns more ids than there are slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= count_t'(SLOTS))
        else $error("list count overran the table");
`endif

endmodule
